[rtl/rmq_pkg.sv]
//------------------------------------------------------------------------------
// rmq_pkg
// Types, widths and helpers for the rotation matrix to quaternion core.
//------------------------------------------------------------------------------
package rmq_pkg;

	localparam int ElemW     = 16;
	localparam int CandW     = 18;
	localparam int RadW      = 31;
	localparam int RootW     = 16;
	localparam int DiffW     = 17;
	localparam int NumW      = 31;
	localparam int QuotW     = 16;
	localparam int SqrtSteps = 16;
	localparam int DivSteps  = 16;

	typedef enum logic [1:0] {
		IDX_W = 2'd0,
		IDX_X = 2'd1,
		IDX_Y = 2'd2,
		IDX_Z = 2'd3
	} idx_t;

	typedef struct packed {
		logic signed [ElemW-1:0] m00;
		logic signed [ElemW-1:0] m01;
		logic signed [ElemW-1:0] m02;
		logic signed [ElemW-1:0] m10;
		logic signed [ElemW-1:0] m11;
		logic signed [ElemW-1:0] m12;
		logic signed [ElemW-1:0] m20;
		logic signed [ElemW-1:0] m21;
		logic signed [ElemW-1:0] m22;
	} matrix_t;

	typedef struct packed {
		logic signed [ElemW-1:0] quat_w;
		logic signed [ElemW-1:0] quat_x;
		logic signed [ElemW-1:0] quat_y;
		logic signed [ElemW-1:0] quat_z;
		logic [1:0]              largest_index;
		logic                    bad_input;
	} quat_t;

	// Front-end result: bad flag, selected radicand, index and the three off-diagonal terms.
	typedef struct packed {
		logic                    bad;
		logic [1:0]              idx;
		logic [RadW-1:0]         rad;
		logic signed [DiffW-1:0] d0;
		logic signed [DiffW-1:0] d1;
		logic signed [DiffW-1:0] d2;
	} sel_t;

endpackage

[rtl/rmq_select.sv]
//------------------------------------------------------------------------------
// rmq_select
// Forms the four candidates, picks the largest and the off-diagonal terms.
//------------------------------------------------------------------------------
module rmq_select (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_in,
	input  rmq_pkg::matrix_t mat,
	output logic            vld_s1,
	output rmq_pkg::sel_t   sel_s1
);
	import rmq_pkg::*;

	logic signed [CandW-1:0] a00, a11, a22, c0, c1, c2, c3, best;
	logic [1:0]              idx;
	logic signed [CandW:0]   r;
	sel_t                    nx;

	always_comb begin
		a00 = CandW'(mat.m00);
		a11 = CandW'(mat.m11);
		a22 = CandW'(mat.m22);
		c0 = a00 + a11 + a22;
		c1 = a00 - a11 - a22;
		c2 = a11 - a00 - a22;
		c3 = a22 - a00 - a11;
		best = c0;
		idx = IDX_W;
		if (c1 > best) begin
			best = c1;
			idx = IDX_X;
		end
		if (c2 > best) begin
			best = c2;
			idx = IDX_Y;
		end
		if (c3 > best) begin
			best = c3;
			idx = IDX_Z;
		end
		r = (CandW+1)'(best) + (CandW+1)'(16384);
		nx.bad = (r <= 0);
		nx.idx = idx;
		nx.rad = {r[16:0], 12'd0, 2'd0} >> 2;
		unique case (idx)
			IDX_W: begin
				nx.d0 = DiffW'(mat.m12) - DiffW'(mat.m21);
				nx.d1 = DiffW'(mat.m20) - DiffW'(mat.m02);
				nx.d2 = DiffW'(mat.m01) - DiffW'(mat.m10);
			end
			IDX_X: begin
				nx.d0 = DiffW'(mat.m12) - DiffW'(mat.m21);
				nx.d1 = DiffW'(mat.m01) + DiffW'(mat.m10);
				nx.d2 = DiffW'(mat.m20) + DiffW'(mat.m02);
			end
			IDX_Y: begin
				nx.d0 = DiffW'(mat.m20) - DiffW'(mat.m02);
				nx.d1 = DiffW'(mat.m01) + DiffW'(mat.m10);
				nx.d2 = DiffW'(mat.m12) + DiffW'(mat.m21);
			end
			default: begin
				nx.d0 = DiffW'(mat.m01) - DiffW'(mat.m10);
				nx.d1 = DiffW'(mat.m20) + DiffW'(mat.m02);
				nx.d2 = DiffW'(mat.m12) + DiffW'(mat.m21);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= nx;
	end

endmodule

[rtl/rmq_sqrt.sv]
//------------------------------------------------------------------------------
// rmq_sqrt
// Pipelined rounded square root, one result bit per stage.
//------------------------------------------------------------------------------
module rmq_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  rmq_pkg::sel_t sel_in,
	output logic          vld_out,
	output rmq_pkg::sel_t sel_out,
	output logic [rmq_pkg::RootW-1:0] root
);
	import rmq_pkg::*;

	logic [SqrtSteps:0]             vld_p;
	sel_t                           sel_p [SqrtSteps+1];
	logic [RootW-1:0]               q_p   [SqrtSteps+1];
	logic [RadW+1:0]                rem_p [SqrtSteps+1];

	assign vld_p[0] = vld_in;
	assign sel_p[0] = sel_in;
	assign q_p[0]   = '0;
	assign rem_p[0] = (RadW+2)'(sel_in.rad);

	for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
		localparam int Sh = 2 * (SqrtSteps - 1 - i);
		logic [RadW+1:0] trial;
		logic [RadW+1:0] sub;
		logic            ok;
		always_comb begin
			trial = ((RadW+2)'({q_p[i], 2'b01})) << Sh;
			ok    = rem_p[i] >= trial;
			sub   = rem_p[i] - trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[i+1] <= 1'b0;
			end else begin
				vld_p[i+1] <= vld_p[i];
			end
		end
		always_ff @(posedge clk) begin
			sel_p[i+1] <= sel_p[i];
			q_p[i+1]   <= {q_p[i][RootW-2:0], ok};
			rem_p[i+1] <= ok ? sub : rem_p[i];
		end
	end

	logic [RadW+1:0] rem_f;
	logic [RootW-1:0] q_f;
	assign rem_f = rem_p[SqrtSteps];
	assign q_f   = q_p[SqrtSteps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_p[SqrtSteps];
		end
	end

	always_ff @(posedge clk) begin
		sel_out <= sel_p[SqrtSteps];
		root    <= (rem_f > (RadW+2)'(q_f)) ? q_f + RootW'(1) : q_f;
	end

endmodule

[rtl/rmq_div.sv]
//------------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider for one scaled, rounded, saturated term.
//------------------------------------------------------------------------------
module rmq_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_in,
	input  logic signed [rmq_pkg::DiffW-1:0] d,
	input  logic [rmq_pkg::RootW-1:0]     b,
	output logic signed [rmq_pkg::ElemW-1:0] q
);
	import rmq_pkg::*;

	// Numerator 2*|d|*4096 + b over divisor 2*b; quotient saturates to the signed 16-bit range.
	localparam int DvW = RootW + 1;

	logic [DivSteps:0]   vld_p;
	logic [DivSteps:0]   neg_p;
	logic [DivSteps:0]   ovf_p;
	logic [DvW-1:0]      dv_p  [DivSteps+1];
	logic [DvW:0]        rem_p [DivSteps+1];
	logic [NumW-1:0]     num_p [DivSteps+1];
	logic [QuotW-1:0]    q_p   [DivSteps+1];

	logic [DiffW-1:0] mag;
	logic [NumW-1:0]  num0;
	logic [DvW-1:0]   dv0;
	logic [NumW:0]    hi_chk;

	always_comb begin
		mag    = d[DiffW-1] ? DiffW'(-d) : d;
		num0   = (NumW'(mag) << 13) + NumW'(b);
		dv0    = {b, 1'b0};
		hi_chk = (NumW+1)'(num0 >> QuotW);
	end

	assign vld_p[0] = vld_in;
	assign neg_p[0] = d[DiffW-1];
	assign ovf_p[0] = hi_chk >= (NumW+1)'(dv0);
	assign dv_p[0]  = dv0;
	assign rem_p[0] = (DvW+1)'(num0 >> QuotW);
	assign num_p[0] = num0;
	assign q_p[0]   = '0;

	for (genvar i = 0; i < DivSteps; i++) begin : g_step
		logic [DvW:0] sh;
		logic         ok;
		always_comb begin
			sh = {rem_p[i][DvW-1:0], num_p[i][QuotW-1-i]};
			ok = sh >= (DvW+1)'(dv_p[i]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[i+1] <= 1'b0;
			end else begin
				vld_p[i+1] <= vld_p[i];
			end
		end
		always_ff @(posedge clk) begin
			neg_p[i+1] <= neg_p[i];
			ovf_p[i+1] <= ovf_p[i];
			dv_p[i+1]  <= dv_p[i];
			num_p[i+1] <= num_p[i];
			rem_p[i+1] <= ok ? sh - (DvW+1)'(dv_p[i]) : sh;
			q_p[i+1]   <= {q_p[i][QuotW-2:0], ok};
		end
	end

	logic [QuotW-1:0] qm;
	logic             big;
	always_comb begin
		qm  = q_p[DivSteps];
		big = ovf_p[DivSteps] || (neg_p[DivSteps] ? qm > 16'd32768 : qm > 16'd32767);
	end

	always_ff @(posedge clk) begin
		if (vld_p[DivSteps]) begin
			if (neg_p[DivSteps]) begin
				q <= big ? 16'sh8000 : ElemW'(-$signed({1'b0, qm}));
			end else begin
				q <= big ? 16'sd32767 : $signed(qm);
			end
		end
	end

endmodule

[rtl/rotation_matrix_to_quaternion_core.sv]
//------------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a Q2.14 rotation matrix into a Q2.14 quaternion.
//------------------------------------------------------------------------------
// Usage: drive mat and raise start; a word is taken at each edge with start
// high and busy low. busy stays low, so one matrix enters every cycle.
// Each result word appears on quat for exactly one cycle with done high,
// in input order, after its matrix passes candidate selection, the
// bit-per-stage square root, the bit-per-stage dividers and one output
// register.
// Throughput is one word per cycle. The receiver cannot stall; done is a
// strobe and the word must be captured when it is shown.
// Reset clears all valid bits, so no done appears until new words enter.
// A matrix whose radicand is not positive gives bad_input with all other
// fields zero.
//------------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rmq_pkg::matrix_t mat,
	output logic             done,
	output rmq_pkg::quat_t   quat
);
	import rmq_pkg::*;

	localparam int AlignSteps = DivSteps + 1;

	logic       vld_s1, vld_r;
	sel_t       sel_s1, sel_r;
	logic [RootW-1:0] root;
	logic signed [ElemW-1:0] q0, q1, q2;
	logic [AlignSteps:0]  vld_d;
	sel_t       sel_d [AlignSteps+1];
	logic [RootW-1:0]   b_d [AlignSteps+1];
	quat_t      nx;

	assign busy = 1'b0;

	rmq_select u_sel (
		.clk(clk), .arst_n(arst_n), .vld_in(start && !busy), .mat(mat),
		.vld_s1(vld_s1), .sel_s1(sel_s1)
	);

	rmq_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s1), .sel_in(sel_s1),
		.vld_out(vld_r), .sel_out(sel_r), .root(root)
	);

	rmq_div u_div0 (.clk(clk), .arst_n(arst_n), .vld_in(vld_r), .d(sel_r.d0),
		.b(root), .q(q0));
	rmq_div u_div1 (.clk(clk), .arst_n(arst_n), .vld_in(vld_r), .d(sel_r.d1),
		.b(root), .q(q1));
	rmq_div u_div2 (.clk(clk), .arst_n(arst_n), .vld_in(vld_r), .d(sel_r.d2),
		.b(root), .q(q2));

	assign vld_d[0] = vld_r;
	assign sel_d[0] = sel_r;
	assign b_d[0]   = root;
	for (genvar i = 0; i < AlignSteps; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[i+1] <= 1'b0;
			end else begin
				vld_d[i+1] <= vld_d[i];
			end
		end
		always_ff @(posedge clk) begin
			sel_d[i+1] <= sel_d[i];
			b_d[i+1]   <= b_d[i];
		end
	end

	always_comb begin
		nx = '0;
		nx.largest_index = sel_d[AlignSteps].idx;
		unique case (sel_d[AlignSteps].idx)
			IDX_W: begin
				nx.quat_w = $signed(b_d[AlignSteps]);
				nx.quat_x = q0;
				nx.quat_y = q1;
				nx.quat_z = q2;
			end
			IDX_X: begin
				nx.quat_w = q0;
				nx.quat_x = $signed(b_d[AlignSteps]);
				nx.quat_y = q1;
				nx.quat_z = q2;
			end
			IDX_Y: begin
				nx.quat_w = q0;
				nx.quat_x = q1;
				nx.quat_y = $signed(b_d[AlignSteps]);
				nx.quat_z = q2;
			end
			default: begin
				nx.quat_w = q0;
				nx.quat_x = q1;
				nx.quat_y = q2;
				nx.quat_z = $signed(b_d[AlignSteps]);
			end
		endcase
		if (sel_d[AlignSteps].bad) begin
			nx = '0;
			nx.bad_input = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_d[AlignSteps];
		end
	end

	always_ff @(posedge clk) begin
		quat <= nx;
	end

endmodule

[rtl/rmq_checker.sv]
//------------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the rotation matrix to quaternion core.
//------------------------------------------------------------------------------
module rmq_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input rmq_pkg::quat_t   quat
);
	import rmq_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("Core reported busy.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##36 done)
		else $error("Result word missing after the pipeline latency.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 36))
		else $error("Result word without a matching input word.");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && quat.bad_input) |-> (quat.quat_w == 0 && quat.quat_x == 0 &&
		quat.quat_y == 0 && quat.quat_z == 0 && quat.largest_index == 0))
		else $error("Bad input word carries nonzero fields.");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .quat(quat)
);
